### rtl/i8mm_pkg.sv
// Shared types and codes for the int8 matrix multiply core.
// Used by i8mm_ctrl, i8mm_datapath and int8_matrix_multiply_core.
package i8mm_pkg;

  localparam logic [1:0] CMD_WRITE_A = 2'd0;
  localparam logic [1:0] CMD_WRITE_B = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  localparam logic [7:0] ELEM_OFFSET = 8'h80;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] row;
    logic [3:0] col;
    logic [7:0] element_byte;
  } i8mm_in_t;

  typedef struct packed {
    logic signed [7:0] product_element;
    logic              index_error;
  } i8mm_out_t;

  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic start;
    logic issue;
    logic load_out;
  } i8mm_cmd_t;

  typedef struct packed {
    logic in_range;
    logic last_step;
    logic busy;
    logic out_free;
  } i8mm_stat_t;

endpackage

### rtl/int8_matrix_multiply_core.sv
// Top level of the int8 matrix multiply core.
// Depends on i8mm_pkg, i8mm_ctrl and i8mm_datapath.
//
// A write word stores one element of A or B. A compute word runs one
// multiply-accumulate step per cycle over single read ports on the A and
// B memories, then waits as needed for the result register to drain; a
// compute outside the active size answers with index_error set. The block
// takes one word at a time; a finished result waits in the output register
// while new writes are accepted. Storage holds MAX_DIM x MAX_DIM elements
// per matrix and needs no clearing after reset.
module int8_matrix_multiply_core
  import i8mm_pkg::*;
#(
  parameter int MAX_DIM = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  i8mm_in_t   in_word,
  output logic       out_valid,
  input  logic       out_ready,
  output i8mm_out_t  out_word,
  input  logic       matrix_size_we,
  input  logic [4:0] matrix_size_wdata
);

  i8mm_cmd_t  cmd;
  i8mm_stat_t stat;

  i8mm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (in_word.command),
    .stat     (stat),
    .cmd      (cmd)
  );

  i8mm_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .in_word           (in_word),
    .matrix_size_we    (matrix_size_we),
    .matrix_size_wdata (matrix_size_wdata),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_word          (out_word)
  );

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> stat.out_free)
    else $error("result loaded over an untaken result");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !stat.busy)
    else $error("input ready while the pipeline is busy");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.start && stat.in_range |=> cmd.issue)
    else $error("in-range compute did not start stepping");

  a_single_write: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_a || cmd.wr_b) |-> !(cmd.wr_a && cmd.wr_b) && in_valid && in_ready)
    else $error("memory write without an accepted word");

endmodule

### rtl/i8mm_ctrl.sv
// Command sequencer for the int8 matrix multiply core.
// Depends on i8mm_pkg; drives i8mm_datapath through i8mm_cmd_t.
module i8mm_ctrl
  import i8mm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] command,
  input  i8mm_stat_t stat,
  output i8mm_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (command)
            CMD_WRITE_A: cmd.wr_a = stat.in_range;
            CMD_WRITE_B: cmd.wr_b = stat.in_range;
            CMD_COMPUTE: begin
              cmd.start  = 1'b1;
              state_next = stat.in_range ? S_RUN : S_DONE;
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        if (stat.last_step) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/i8mm_datapath.sv
// Matrix storage, multiply-accumulate pipeline and result register.
// Depends on i8mm_pkg; sequenced by i8mm_ctrl.
module i8mm_datapath
  import i8mm_pkg::*;
#(
  parameter int MAX_DIM = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  i8mm_in_t   in_word,
  input  logic       matrix_size_we,
  input  logic [4:0] matrix_size_wdata,
  input  i8mm_cmd_t  cmd,
  output i8mm_stat_t stat,
  output logic       out_valid,
  input  logic       out_ready,
  output i8mm_out_t  out_word
);

  localparam int CELLS  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int K_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic [7:0] mem_a [CELLS];
  logic [7:0] mem_b [CELLS];

  logic [4:0]       size_q;
  logic [3:0]       row_q;
  logic [3:0]       col_q;
  logic             err_q;
  logic [K_W-1:0]   k;
  logic [7:0]       a_rd;
  logic [7:0]       b_rd;
  logic             rd_vld;
  logic [7:0]       prod;
  logic             mul_vld;
  logic [7:0]       acc;
  logic [31:0]      waddr_full;
  logic [31:0]      raddr_a_full;
  logic [31:0]      raddr_b_full;
  logic signed [15:0] mul;

  assign waddr_full   = 32'(in_word.row) * 32'(MAX_DIM) + 32'(in_word.col);
  assign raddr_a_full = 32'(row_q) * 32'(MAX_DIM) + 32'(k);
  assign raddr_b_full = 32'(k) * 32'(MAX_DIM) + 32'(col_q);
  assign mul          = $signed(a_rd) * $signed(b_rd);

  assign stat.in_range  = ({1'b0, in_word.row} < size_q) && ({1'b0, in_word.col} < size_q);
  assign stat.last_step = (32'(k) + 32'd1) == 32'(size_q);
  assign stat.busy      = rd_vld | mul_vld;
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (matrix_size_we && (32'(matrix_size_wdata) <= 32'(MAX_DIM))) begin
      size_q <= matrix_size_wdata;
    end
    if (rst) begin
      size_q <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      mem_a[waddr_full[ADDR_W-1:0]] <= in_word.element_byte ^ ELEM_OFFSET;
    end
    if (cmd.wr_b) begin
      mem_b[waddr_full[ADDR_W-1:0]] <= in_word.element_byte ^ ELEM_OFFSET;
    end
    if (cmd.issue) begin
      a_rd <= mem_a[raddr_a_full[ADDR_W-1:0]];
      b_rd <= mem_b[raddr_b_full[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row_q <= in_word.row;
      col_q <= in_word.col;
      err_q <= !stat.in_range;
      k     <= '0;
    end else if (cmd.issue) begin
      k <= k + K_W'(1);
    end
    prod <= mul[7:0];
    if (cmd.start) begin
      acc <= '0;
    end else if (mul_vld) begin
      acc <= acc + prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld  <= 1'b0;
      mul_vld <= 1'b0;
    end else begin
      rd_vld  <= cmd.issue;
      mul_vld <= rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_word.index_error     <= err_q;
      out_word.product_element <= err_q ? 8'sd0 : $signed(acc);
    end
  end

endmodule

### bench/tb.sv
// Testbench for int8_matrix_multiply_core: element writes, size settings and
// product computes, with each result word checked against an in-bench predictor.
// Depends on i8mm_pkg and the core RTL only.
module tb
  import i8mm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM = 16;
  localparam int SETTLE = DIM + 8;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  i8mm_in_t   in_word = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  i8mm_out_t  out_word;
  logic       matrix_size_we = 1'b0;
  logic [4:0] matrix_size_wdata = '0;

  logic [4:0]        size_q = '0;
  logic signed [7:0] elem_a [DIM*DIM];
  logic signed [7:0] elem_b [DIM*DIM];
  bit                set_a [DIM*DIM];
  bit                set_b [DIM*DIM];
  i8mm_out_t         product_q [$];
  i8mm_out_t         want;
  bit                no_gaps = 1'b0;
  int                n_errors = 0;
  int                n_products = 0;
  int                n_writes = 0;
  int                n_sizes = 0;

  always #5 clk = ~clk;

  int8_matrix_multiply_core #(.MAX_DIM(DIM)) DUT (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_word           (in_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_word          (out_word),
    .matrix_size_we    (matrix_size_we),
    .matrix_size_wdata (matrix_size_wdata)
  );

  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_elem();
    if ($urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 3))
        0: return 8'h00;
        1: return 8'hff;
        2: return 8'h7f;
        default: return 8'h80;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic i8mm_out_t predict_product(logic [3:0] r, logic [3:0] c);
    int acc;
    int k;
    i8mm_out_t res;
    acc = 0;
    res = '0;
    if (r >= size_q || c >= size_q) begin
      res.index_error = 1'b1;
      return res;
    end
    for (k = 0; k < size_q; k++)
      acc += int'(elem_a[r*DIM+k]) * int'(elem_b[k*DIM+c]);
    res.product_element = acc[7:0];
    return res;
  endfunction

  // hold the word until taken, then advance the predictor
  task automatic send_word(input i8mm_in_t w);
    int g;
    int idx;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    idx = w.row * DIM + w.col;
    case (w.command)
      CMD_WRITE_A: begin
        if (w.row < size_q && w.col < size_q) begin
          elem_a[idx] = w.element_byte - ELEM_OFFSET;
          set_a[idx] = 1'b1;
          n_writes++;
        end
      end
      CMD_WRITE_B: begin
        if (w.row < size_q && w.col < size_q) begin
          elem_b[idx] = w.element_byte - ELEM_OFFSET;
          set_b[idx] = 1'b1;
          n_writes++;
        end
      end
      CMD_COMPUTE: product_q.push_back(predict_product(w.row, w.col));
      default: ;
    endcase
  endtask

  task automatic send_cmd(input logic [1:0] cmd, input logic [3:0] r, input logic [3:0] c,
                          input logic [7:0] value);
    i8mm_in_t w;
    w.command = cmd;
    w.row = r;
    w.col = c;
    w.element_byte = value;
    send_word(w);
  endtask

  // fill any element the dot product needs that was never written, then send the compute
  task automatic compute_at(input logic [3:0] r, input logic [3:0] c);
    int k;
    if (r < size_q && c < size_q) begin
      for (k = 0; k < size_q; k++) begin
        if (!set_a[r*DIM+k]) send_cmd(CMD_WRITE_A, r, 4'(k), rand_elem());
        if (!set_b[k*DIM+c]) send_cmd(CMD_WRITE_B, 4'(k), c, rand_elem());
      end
    end
    send_cmd(CMD_COMPUTE, r, c, 8'($urandom_range(0, 255)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (product_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_size(input logic [4:0] v);
    drain();
    matrix_size_we <= 1'b1;
    matrix_size_wdata <= v;
    @(posedge clk);
    matrix_size_we <= 1'b0;
    if (v <= DIM) size_q = v;
    n_sizes++;
  endtask

  task automatic test_after_reset();
    compute_at(4'd0, 4'd0);
    compute_at(4'd15, 4'd15);
    send_cmd(CMD_WRITE_A, 4'd0, 4'd0, 8'h55);
    send_cmd(CMD_UNUSED, 4'd15, 4'd15, 8'hff);
  endtask

  task automatic test_size_register();
    set_size(5'd2);
    set_size(5'(DIM + 1));
    set_size(5'd31);
  endtask

  task automatic test_small_products();
    send_cmd(CMD_WRITE_A, 4'd0, 4'd0, 8'h00);
    send_cmd(CMD_WRITE_A, 4'd0, 4'd1, 8'hff);
    send_cmd(CMD_WRITE_A, 4'd1, 4'd0, 8'h80);
    send_cmd(CMD_WRITE_A, 4'd1, 4'd1, 8'h01);
    send_cmd(CMD_WRITE_B, 4'd0, 4'd0, 8'h00);
    send_cmd(CMD_WRITE_B, 4'd0, 4'd1, 8'hff);
    send_cmd(CMD_WRITE_B, 4'd1, 4'd0, 8'h00);
    send_cmd(CMD_WRITE_B, 4'd1, 4'd1, 8'h80);
    compute_at(4'd0, 4'd0);
    compute_at(4'd0, 4'd1);
    compute_at(4'd1, 4'd0);
    compute_at(4'd1, 4'd1);
    send_cmd(CMD_WRITE_B, 4'd1, 4'd2, 8'h3c);
    compute_at(4'd2, 4'd0);
    compute_at(4'd0, 4'd15);
  endtask

  task automatic test_random_phases();
    int sizes [8];
    int p;
    int i;
    int r;
    logic [3:0] row;
    logic [3:0] col;
    sizes = '{1, DIM, 0, $urandom_range(2, 15), $urandom_range(2, 15), DIM,
              $urandom_range(1, DIM), $urandom_range(1, 15)};
    for (p = 0; p < 8; p++) begin
      set_size(5'(sizes[p]));
      if ($urandom_range(0, 2) == 0) set_size(5'($urandom_range(DIM + 1, 31)));
      no_gaps = (p == 3 || p == 6);
      for (i = 0; i < 90; i++) begin
        r = $urandom_range(0, 99);
        if (r < 50 && size_q > 0) begin
          compute_at(4'($urandom_range(0, size_q - 1)), 4'($urandom_range(0, size_q - 1)));
        end else if (r < 62) begin
          row = 4'($urandom_range(0, 15));
          col = 4'($urandom_range(0, 15));
          if (size_q < DIM) begin
            if ($urandom_range(0, 1)) row = 4'($urandom_range(size_q, 15));
            else col = 4'($urandom_range(size_q, 15));
          end
          compute_at(row, col);
        end else if (r < 90 && size_q > 0) begin
          send_cmd($urandom_range(0, 1) ? CMD_WRITE_B : CMD_WRITE_A,
                   4'($urandom_range(0, size_q - 1)), 4'($urandom_range(0, size_q - 1)),
                   rand_elem());
        end else if (r < 95) begin
          send_cmd(CMD_UNUSED, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   8'($urandom_range(0, 255)));
        end else begin
          send_cmd($urandom_range(0, 1) ? CMD_WRITE_B : CMD_WRITE_A,
                   4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), rand_elem());
        end
      end
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    @(posedge clk);
    forever begin
      if (gap_len() == 0) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (product_q.size() == 0) begin
        n_errors++;
        $display("%0t: result word with none expected: product %0d err %0b", $time,
                 out_word.product_element, out_word.index_error);
      end else begin
        want = product_q.pop_front();
        n_products++;
        if (out_word.product_element !== want.product_element) begin
          n_errors++;
          $display("%0t: product_element expected %0d, got %0d", $time,
                   want.product_element, out_word.product_element);
        end
        if (out_word.index_error !== want.index_error) begin
          n_errors++;
          $display("%0t: index_error expected %0b, got %0b", $time,
                   want.index_error, out_word.index_error);
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_after_reset();
    test_size_register();
    test_small_products();
    test_random_phases();
    drain();
    $display("covered %0d size writes, %0d element writes, %0d result words, %0d mismatches",
             n_sizes, n_writes, n_products, n_errors);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### int8_matrix_multiply_core.f
rtl/i8mm_pkg.sv
rtl/i8mm_ctrl.sv
rtl/i8mm_datapath.sv
rtl/int8_matrix_multiply_core.sv
bench/tb.sv
